@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion macros; clk and rst_n must be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that trig is followed in the next cycle by expect_next.
`define ASSERT_NEXT(label, trig, expect_next, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |=> (expect_next)) else $error(msg);

`endif

@@ hw/rtl/cmmfr_pkg.sv @@
package cmmfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 64;
    localparam int WORD_INDEX_W = 3;

    localparam logic [BYTE_W-1:0] START_MARK = 8'hFC;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'hFD;
    localparam logic [BYTE_W-1:0] HDR_TYPE   = 8'h41;
    localparam logic [BYTE_W-1:0] HDR_LEN    = 8'h30;

    localparam logic FUNC_PAYLOAD = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte3;
        logic [BYTE_W-1:0] byte4;
        logic [BYTE_W-1:0] byte5;
        logic [BYTE_W-1:0] byte6;
        logic [BYTE_W-1:0] byte7;
    } in_item_t;

    typedef struct packed {
        logic                    kind;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]       frame_word;
        logic                    last;
        logic                    alive;
    } out_item_t;

    typedef struct packed {
        logic accept_payload;
        logic accept_tick;
        logic load_word;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_ready;
        logic last_loaded;
    } dp_status_t;

endpackage

@@ hw/rtl/cmmfr_stream_if.sv @@
interface cmmfr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/can_multi_message_frame_reassembler.sv @@
// Channel   Direction  Payload                                   Transaction
// payload   in         func, byte0..byte7                        valid & ready
// result    out        kind, word_index, frame_word, last, alive valid & ready
//
// A payload or tick is taken in one valid & ready transaction; a completed accepted frame then
// streams FRAME_SLOTS words from the slot store, one per cycle through the
// output register, as long as result is not stalled.
// No input is taken while words stream out; a stalled result holds everything.
// rst_n clears control state asynchronously; the slot store is not cleared.
module can_multi_message_frame_reassembler #(
    parameter int FRAME_SLOTS = 7
) (
    input logic            clk,
    input logic            rst_n,
    cmmfr_stream_if.sink   payload,
    cmmfr_stream_if.source result
);
    cmmfr_pkg::dp_cmd_t    cmd;
    cmmfr_pkg::dp_status_t status;

    cmmfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (payload.valid),
        .in_func   (payload.data.func),
        .in_ready  (payload.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cmmfr_datapath #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (payload.data),
        .cmd      (cmd),
        .status   (status),
        .out_item (result.data)
    );

endmodule

@@ hw/rtl/cmmfr_datapath.sv @@
module cmmfr_datapath #(
    parameter int FRAME_SLOTS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmmfr_pkg::in_item_t   in_item,
    input  cmmfr_pkg::dp_cmd_t    cmd,
    output cmmfr_pkg::dp_status_t status,
    output cmmfr_pkg::out_item_t  out_item
);
    localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);
    localparam int IW     = cmmfr_pkg::WORD_INDEX_W;

    logic [cmmfr_pkg::WORD_W-1:0] slot_store [FRAME_SLOTS];

    logic [cmmfr_pkg::BYTE_W-1:0] prev_end_reg, prev_end_next;
    logic [CNT_W-1:0]             slot_cnt_reg, slot_cnt_next;
    logic                         header_ok_reg, header_ok_next;
    logic                         received_mark_reg, received_mark_next;
    logic [SLOT_W-1:0]            rd_idx_reg, rd_idx_next;

    logic                          out_kind_reg;
    logic [IW-1:0]                 out_index_reg;
    logic [cmmfr_pkg::WORD_W-1:0]  out_word_reg;
    logic                          out_last_reg;
    logic                          out_alive_reg;

    logic                         start;
    logic                         hdr_match;
    logic [CNT_W-1:0]             cnt_eff;
    logic                         hdr_eff;
    logic                         frame_full;
    logic                         store_write;
    logic [SLOT_W-1:0]            wr_idx;
    logic [cmmfr_pkg::WORD_W-1:0] word;

    assign word = {in_item.byte7, in_item.byte6, in_item.byte5, in_item.byte4,
                   in_item.byte3, in_item.byte2, in_item.byte1, in_item.byte0};

    assign start      = (in_item.byte0 == cmmfr_pkg::START_MARK)
                     && (prev_end_reg == cmmfr_pkg::END_MARK);
    assign hdr_match  = (in_item.byte1 == cmmfr_pkg::HDR_TYPE)
                     && (in_item.byte2 == cmmfr_pkg::HDR_LEN);
    assign cnt_eff    = start ? CNT_W'(1) : slot_cnt_reg;
    assign hdr_eff    = start ? hdr_match : header_ok_reg;
    assign frame_full = (cnt_eff == CNT_W'(FRAME_SLOTS));
    assign wr_idx     = SLOT_W'(cnt_eff - CNT_W'(1));
    assign store_write = cmd.accept_payload && (cnt_eff != '0);

    assign status.frame_ready = (cnt_eff != '0) && frame_full && hdr_eff;
    assign status.last_loaded = (rd_idx_reg == SLOT_W'(FRAME_SLOTS - 1));

    always_comb
    begin
        prev_end_next      = prev_end_reg;
        slot_cnt_next      = slot_cnt_reg;
        header_ok_next     = header_ok_reg;
        received_mark_next = received_mark_reg;
        rd_idx_next        = rd_idx_reg;
        if (cmd.accept_tick)
        begin
            received_mark_next = 1'b0;
        end
        if (cmd.accept_payload)
        begin
            received_mark_next = 1'b1;
            prev_end_next      = in_item.byte7;
            rd_idx_next        = '0;
            if (cnt_eff == '0)
            begin
                slot_cnt_next = '0;
            end
            else if (frame_full)
            begin
                slot_cnt_next  = '0;
                header_ok_next = 1'b0;
            end
            else
            begin
                slot_cnt_next  = cnt_eff + CNT_W'(1);
                header_ok_next = hdr_eff;
            end
        end
        if (cmd.load_word)
        begin
            rd_idx_next = rd_idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg      <= '0;
            slot_cnt_reg      <= '0;
            header_ok_reg     <= 1'b0;
            received_mark_reg <= 1'b0;
            rd_idx_reg        <= '0;
        end
        else
        begin
            prev_end_reg      <= prev_end_next;
            slot_cnt_reg      <= slot_cnt_next;
            header_ok_reg     <= header_ok_next;
            received_mark_reg <= received_mark_next;
            rd_idx_reg        <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_write)
        begin
            slot_store[wr_idx] <= word;
        end
    end

    // The output register takes a slot store word read combinationally at rd_idx_reg, or a status item on a tick.
    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            out_kind_reg  <= cmmfr_pkg::KIND_WORD;
            out_index_reg <= IW'(rd_idx_reg);
            out_word_reg  <= slot_store[rd_idx_reg];
            out_last_reg  <= status.last_loaded;
            out_alive_reg <= 1'b0;
        end
        else if (cmd.accept_tick)
        begin
            out_kind_reg  <= cmmfr_pkg::KIND_STATUS;
            out_index_reg <= '0;
            out_word_reg  <= '0;
            out_last_reg  <= 1'b1;
            out_alive_reg <= received_mark_reg;
        end
    end

    assign out_item.kind       = out_kind_reg;
    assign out_item.word_index = out_index_reg;
    assign out_item.frame_word = out_word_reg;
    assign out_item.last       = out_last_reg;
    assign out_item.alive      = out_alive_reg;

endmodule

@@ hw/rtl/cmmfr_ctrl.sv @@
`include "assert_macros.svh"

module cmmfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_func,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  cmmfr_pkg::dp_status_t status,
    output cmmfr_pkg::dp_cmd_t    cmd
);
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   in_take;

    assign out_free = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_take)
                begin
                    if (in_func == cmmfr_pkg::FUNC_TICK)
                    begin
                        cmd.accept_tick = 1'b1;
                        out_valid_next  = 1'b1;
                    end
                    else
                    begin
                        cmd.accept_payload = 1'b1;
                        if (status.frame_ready)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_word  = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last_loaded)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_frame_enters_emit, cmd.accept_payload && status.frame_ready,
        state_reg == ST_EMIT, "completed frame did not start emission")
    `ASSERT_NEXT(a_last_word_leaves_emit, cmd.load_word && status.last_loaded,
        state_reg == ST_IDLE && out_valid_reg, "emission did not end after last word")
    `ASSERT_CLK(a_load_excludes_accept,
        !(cmd.load_word && (cmd.accept_payload || cmd.accept_tick)),
        "word load overlaps input transaction")

endmodule
